### rtl/core/mass_spring_membrane_step_macros.svh
// ----------------------------------------------------------------------------
// mass_spring_membrane_step_macros
// Assertion macros shared by the membrane step modules.
// ----------------------------------------------------------------------------
`ifndef MASS_SPRING_MEMBRANE_STEP_MACROS_SVH
`define MASS_SPRING_MEMBRANE_STEP_MACROS_SVH
`ifndef SYNTHESIS
// condition that must hold at every edge
`define MSM_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("msm: check failed");
// consequence that must hold in the cycle after the antecedent
`define MSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msm: check failed");
`else
`define MSM_ASSERT(lbl, cond)
`define MSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Shared codes, command bundle and defaults of the membrane step block.
// ----------------------------------------------------------------------------
package msm_pkg;

	localparam int GRID_MAX_DEF = 64;

	// item actions
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_SET     = 3'd1;
	localparam logic [2:0] ACT_FORCE   = 3'd2;
	localparam logic [2:0] ACT_PATTERN = 3'd3;
	localparam logic [2:0] ACT_READ    = 3'd4;

	// datapath commands
	localparam logic [3:0] CMD_NONE    = 4'd0;
	localparam logic [3:0] CMD_CLEAR   = 4'd1;
	localparam logic [3:0] CMD_UPDATE  = 4'd2;
	localparam logic [3:0] CMD_FORCE   = 4'd3;
	localparam logic [3:0] CMD_PREP    = 4'd4;
	localparam logic [3:0] CMD_PATTERN = 4'd5;
	localparam logic [3:0] CMD_SET     = 4'd6;
	localparam logic [3:0] CMD_ADDF_RD = 4'd7;
	localparam logic [3:0] CMD_ADDF_WR = 4'd8;
	localparam logic [3:0] CMD_READ    = 4'd9;

	// neighbour steps of the force pass
	localparam logic [3:0] NB_SELF   = 4'd0;
	localparam logic [3:0] NB_LEFT   = 4'd1;
	localparam logic [3:0] NB_RIGHT  = 4'd2;
	localparam logic [3:0] NB_UP     = 4'd3;
	localparam logic [3:0] NB_DOWN   = 4'd4;
	localparam logic [3:0] NB_UL     = 4'd5;
	localparam logic [3:0] NB_DR     = 4'd6;
	localparam logic [3:0] NB_ANTI_A = 4'd7;
	localparam logic [3:0] NB_ANTI_B = 4'd8;
	localparam logic [3:0] NB_LAST   = NB_ANTI_B;

	// register indexes
	localparam logic [2:0] REG_GRID_SIZE     = 3'd0;
	localparam logic [2:0] REG_SPRING_ORTH   = 3'd1;
	localparam logic [2:0] REG_SPRING_DIAG   = 3'd2;
	localparam logic [2:0] REG_SPRING_GROUND = 3'd3;
	localparam logic [2:0] REG_DAMP_ORTH     = 3'd4;
	localparam logic [2:0] REG_DAMP_DIAG     = 3'd5;
	localparam logic [2:0] REG_DAMP_GROUND   = 3'd6;

	localparam logic [6:0]        GRID_SIZE_RST   = 7'd50;
	localparam logic signed [17:0] SPRING_ORTH_RST = 18'sd3277;
	localparam logic signed [17:0] DAMP_ORTH_RST   = 18'sd6554;

	typedef struct packed {
		logic [3:0] op;
		logic [3:0] nb;
		logic       accept;
		logic       load_out;
	} cmd_t;

endpackage

### rtl/core/mass_spring_membrane_step.sv
// ----------------------------------------------------------------------------
// mass_spring_membrane_step
// Mass-spring membrane on a square grid: tick, set, force, pattern, read.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready with action, col, row, amount and pattern;
// every item gives exactly one result beat on out_valid/out_ready carrying
// status, height_out and velocity_out. One item is worked on at a time;
// in_ready is high only while the sequencer is idle.
// The tick cost is set by the single read port of the grid memories: one cell
// per cycle in the update pass, one neighbour per cycle in the force pass.
// After reset the four grid memories are zeroed in a sweep over all
// GRID_MAX*GRID_MAX cells (4096 by default) before the first item is taken;
// configuration writes are taken during it.
// A finished result sits in the output register until out_ready; the next
// item is taken at once, and only its result waits for the register to drain.
// Configuration writes on cfg_we/cfg_index/cfg_data only while idle.
// ----------------------------------------------------------------------------
module mass_spring_membrane_step #(
	parameter int GRID_MAX = msm_pkg::GRID_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [17:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic [5:0]         col,
	input  logic [5:0]         row,
	input  logic signed [23:0] amount,
	input  logic [3:0]         pattern,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [23:0] height_out,
	output logic signed [23:0] velocity_out
);
	import msm_pkg::*;

	localparam int CW = $clog2(GRID_MAX);

	cmd_t          cmd;
	logic [CW-1:0] ci, cj;
	logic [CW:0]   grid_n;

	msm_ctrl #(.GRID_MAX(GRID_MAX)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.grid_n    (grid_n),
		.cmd       (cmd),
		.ci        (ci),
		.cj        (cj)
	);

	msm_dp #(.GRID_MAX(GRID_MAX)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.ci           (ci),
		.cj           (cj),
		.grid_n       (grid_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.col          (col),
		.row          (row),
		.amount       (amount),
		.pattern      (pattern),
		.status       (status),
		.height_out   (height_out),
		.velocity_out (velocity_out)
	);

endmodule

### rtl/core/msm_dp.sv
// ----------------------------------------------------------------------------
// msm_dp
// Grid memories, configuration registers, cell update and force pipelines.
// ----------------------------------------------------------------------------
module msm_dp #(
	parameter int GRID_MAX = msm_pkg::GRID_MAX_DEF,
	localparam int CW = $clog2(GRID_MAX)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  msm_pkg::cmd_t       cmd,
	input  logic [CW-1:0]       ci,
	input  logic [CW-1:0]       cj,
	output logic [CW:0]         grid_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [17:0]         cfg_data,
	input  logic [2:0]          action,
	input  logic [5:0]          col,
	input  logic [5:0]          row,
	input  logic signed [23:0]  amount,
	input  logic [3:0]          pattern,
	output logic                status,
	output logic signed [23:0]  height_out,
	output logic signed [23:0]  velocity_out
);
	import msm_pkg::*;

	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = (CW + 1 > 7) ? CW + 1 : 7;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] i, input logic [CW-1:0] j);
		cell_addr = AW'(i * GRID_MAX + j);
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		if (v > 34'sd8388607)
			sat24 = 24'sd8388607;
		else if (v < -34'sd8388608)
			sat24 = -24'sd8388608;
		else
			sat24 = v[23:0];
	endfunction

	// configuration
	logic [6:0]         grid_q;
	logic signed [17:0] k_orth_q, k_diag_q, k_gnd_q, d_orth_q, d_diag_q, d_gnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q   <= GRID_SIZE_RST;
			k_orth_q <= SPRING_ORTH_RST;
			k_diag_q <= '0;
			k_gnd_q  <= '0;
			d_orth_q <= DAMP_ORTH_RST;
			d_diag_q <= '0;
			d_gnd_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_SIZE:     grid_q   <= cfg_data[6:0];
				REG_SPRING_ORTH:   k_orth_q <= cfg_data;
				REG_SPRING_DIAG:   k_diag_q <= cfg_data;
				REG_SPRING_GROUND: k_gnd_q  <= cfg_data;
				REG_DAMP_ORTH:     d_orth_q <= cfg_data;
				REG_DAMP_DIAG:     d_diag_q <= cfg_data;
				REG_DAMP_GROUND:   d_gnd_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// side length in use, clamped
	logic [SW-1:0] gs_w, n_w, nm1_w;
	logic [CW-1:0] last_c;
	assign gs_w   = SW'(grid_q);
	assign n_w    = (gs_w < SW'(3)) ? SW'(3) : (gs_w > SW'(GRID_MAX)) ? SW'(GRID_MAX) : gs_w;
	assign nm1_w  = n_w - SW'(1);
	assign grid_n = n_w[CW:0];
	assign last_c = nm1_w[CW-1:0];

	// item latch
	logic [2:0]         act_q;
	logic [5:0]         col_q, row_q;
	logic signed [23:0] amt_q;
	logic [3:0]         pat_q;
	logic [3:0]         spat_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q <= action;
			col_q <= col;
			row_q <= row;
			amt_q <= amount;
			pat_q <= pattern;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			spat_q <= 4'd1;
		else if (cmd.op == CMD_PREP && pat_q >= 4'd1 && pat_q <= 4'd8)
			spat_q <= pat_q;
	end

	logic [SW-1:0] col_w, row_w;
	logic          inner, readable;
	logic [AW-1:0] item_addr;
	assign col_w     = SW'(col_q);
	assign row_w     = SW'(row_q);
	assign inner     = col_w != '0 && col_w < nm1_w && row_w != '0 && row_w < nm1_w;
	assign readable  = col_w < n_w && row_w < n_w;
	assign item_addr = cell_addr(CW'(col_q), CW'(row_q));

	// pattern thresholds, division by constants through reciprocals
	logic [31:0]        n32;
	logic [CW:0]        third_q, two3_q, three4_q, half_q;
	logic signed [23:0] q4_q, q6_q, spike_q;
	assign n32 = 32'(grid_n);

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_PREP) begin
			third_q  <= (CW+1)'((n32 * 32'd683) >> 11);
			two3_q   <= (CW+1)'(((n32 << 1) * 32'd683) >> 11);
			three4_q <= (CW+1)'((n32 * 32'd3) >> 2);
			half_q   <= (CW+1)'(n32 >> 1);
			q4_q     <= 24'((n32 >> 2) << 12);
			q6_q     <= 24'(((n32 * 32'd683) >> 12) << 12);
			spike_q  <= 24'(n32 * 32'd6144);
		end
	end

	logic [CW:0]          ci_w, cj_w;
	logic signed [CW+2:0] diag_s;
	logic                 border, mid;
	logic signed [23:0]   pat_h;
	assign ci_w   = {1'b0, ci};
	assign cj_w   = {1'b0, cj};
	assign diag_s = $signed({2'b0, grid_n}) - $signed({3'b0, ci}) - $signed({3'b0, cj});
	assign border = ci == '0 || cj == '0 || ci == last_c || cj == last_c;
	assign mid    = ci_w > third_q && cj_w > third_q && ci_w < two3_q && cj_w < two3_q;

	always_comb begin
		pat_h = '0;
		if (!border) begin
			case (spat_q)
				4'd2: pat_h = (ci == cj && ci_w == half_q) ? spike_q : '0;
				4'd3: pat_h = (diag_s < $signed((CW+3)'(3)) && !diag_s[CW+2] && diag_s != '0)
					? q6_q : '0;
				4'd4: pat_h = (ci == CW'(1)) ? q4_q : '0;
				4'd5: pat_h = mid ? '0 : q4_q;
				4'd6: pat_h = mid ? q4_q : '0;
				4'd7: pat_h = (diag_s < $signed((CW+3)'(3))) ? q6_q : '0;
				4'd8: pat_h = (ci_w > three4_q && cj_w > three4_q) ? q4_q : '0;
				default: pat_h = '0;
			endcase
		end
	end

	// neighbour selection for the force pass
	logic [CW-1:0] ni, nj;
	logic          nb_en, nb_is_a, nb_diag, cell_in;
	assign cell_in = ci != '0 && ci < last_c && cj != '0 && cj < last_c;

	always_comb begin
		ni      = ci;
		nj      = cj;
		nb_en   = 1'b0;
		nb_is_a = 1'b1;
		nb_diag = 1'b0;
		case (cmd.nb)
			NB_SELF: nb_en = cell_in;
			NB_LEFT: begin
				nj    = cj - 1'b1;
				nb_en = ci != '0 && cj != '0;
			end
			NB_RIGHT: begin
				nj      = cj + 1'b1;
				nb_en   = ci != '0 && cj < last_c;
				nb_is_a = 1'b0;
			end
			NB_UP: begin
				ni    = ci - 1'b1;
				nb_en = ci != '0 && cj != '0;
			end
			NB_DOWN: begin
				ni      = ci + 1'b1;
				nb_en   = cj != '0 && ci < last_c;
				nb_is_a = 1'b0;
			end
			NB_UL: begin
				ni      = ci - 1'b1;
				nj      = cj - 1'b1;
				nb_en   = ci != '0 && cj != '0;
				nb_diag = 1'b1;
			end
			NB_DR: begin
				ni      = ci + 1'b1;
				nj      = cj + 1'b1;
				nb_en   = ci < last_c && cj < last_c;
				nb_is_a = 1'b0;
				nb_diag = 1'b1;
			end
			NB_ANTI_A: begin
				ni      = ci + 1'b1;
				nj      = cj - 1'b1;
				nb_en   = ci < last_c && cj != '0;
				nb_diag = 1'b1;
			end
			NB_ANTI_B: begin
				ni      = ci - 1'b1;
				nj      = cj + 1'b1;
				nb_en   = ci != '0 && cj < last_c;
				nb_is_a = 1'b0;
				nb_diag = 1'b1;
			end
			default: ;
		endcase
	end

	// memory read side
	logic [AW-1:0] cur_addr, rd_addr;
	logic          rd_en;
	assign cur_addr = cell_addr(ci, cj);
	assign rd_en = cmd.op == CMD_UPDATE || cmd.op == CMD_FORCE || cmd.op == CMD_ADDF_RD
		|| cmd.op == CMD_READ;

	always_comb begin
		case (cmd.op)
			CMD_FORCE:   rd_addr = cell_addr(ni, nj);
			CMD_ADDF_RD: rd_addr = item_addr;
			CMD_READ:    rd_addr = item_addr;
			default:     rd_addr = cur_addr;
		endcase
	end

	logic signed [23:0] h_mem  [DEPTH];
	logic signed [23:0] oh_mem [DEPTH];
	logic signed [23:0] v_mem  [DEPTH];
	logic signed [23:0] f_mem  [DEPTH];
	logic signed [23:0] h_rd, oh_rd, v_rd, f_rd;

	// cell update pipeline
	logic          uv_s1, uin_s1;
	logic [AW-1:0] addr_s1;
	logic signed [23:0] v_new, h_new;
	assign v_new = sat24(34'(v_rd) + 34'(f_rd));
	assign h_new = sat24(34'(h_rd) + 34'(v_new));

	// force pipeline, stage one sits behind the memory read
	logic fv_s1, en_s1, self_s1, isa_s1, diag_s1, last_s1;
	logic signed [23:0] hc_q, ohc_q;
	logic v_s2, en_s2, neg_s2, dbl_s2, first_s2, last_s2;
	logic v_s3, en_s3, neg_s3, dbl_s3, first_s3, last_s3;
	logic last_s4;
	logic [AW-1:0] addr_s2, addr_s3, addr_s4;
	logic signed [24:0] x1_s2;
	logic signed [25:0] x2_s2;
	logic signed [17:0] k_s2, d_s2;
	logic signed [42:0] p1_s3;
	logic signed [43:0] p2_s3;
	logic signed [33:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uv_s1   <= 1'b0;
			fv_s1   <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			last_s4 <= 1'b0;
		end else begin
			uv_s1   <= cmd.op == CMD_UPDATE;
			fv_s1   <= cmd.op == CMD_FORCE;
			v_s2    <= fv_s1;
			v_s3    <= v_s2;
			last_s4 <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		uin_s1  <= cell_in;
		addr_s1 <= cur_addr;
		en_s1   <= nb_en;
		self_s1 <= cmd.nb == NB_SELF;
		isa_s1  <= nb_is_a;
		diag_s1 <= nb_diag;
		last_s1 <= cmd.nb == NB_LAST;
	end

	logic signed [24:0] dh, x1_c;
	logic signed [24:0] doh;
	logic signed [25:0] x2_c;
	logic signed [17:0] k_c, d_c;

	always_comb begin
		if (isa_s1) begin
			dh  = 25'(hc_q) - 25'(h_rd);
			doh = 25'(ohc_q) - 25'(oh_rd);
		end else begin
			dh  = 25'(h_rd) - 25'(hc_q);
			doh = 25'(oh_rd) - 25'(ohc_q);
		end
		if (self_s1) begin
			x1_c = 25'(h_rd);
			x2_c = 26'(h_rd) - 26'(oh_rd);
			k_c  = k_gnd_q;
			d_c  = d_gnd_q;
		end else begin
			x1_c = dh;
			x2_c = 26'(dh) - 26'(doh);
			k_c  = diag_s1 ? k_diag_q : k_orth_q;
			d_c  = diag_s1 ? d_diag_q : d_orth_q;
		end
	end

	// rounding: add half, floor after the 16 bit shift
	logic signed [43:0] q1;
	logic signed [44:0] q2;
	logic signed [33:0] t_sum, acc_next;
	assign q1 = 44'(p1_s3) + 44'sd32768;
	assign q2 = 45'(p2_s3) + 45'sd32768;
	assign t_sum = 34'($signed(q1[43:16]))
		+ (dbl_s3 ? (34'($signed(q2[44:16])) <<< 1) : 34'($signed(q2[44:16])));
	assign acc_next = (first_s3 ? 34'sd0 : acc_q) + (en_s3 ? (neg_s3 ? -t_sum : t_sum) : 34'sd0);

	always_ff @(posedge clk) begin
		if (fv_s1 && self_s1) begin
			hc_q  <= h_rd;
			ohc_q <= oh_rd;
		end
		x1_s2    <= x1_c;
		x2_s2    <= x2_c;
		k_s2     <= k_c;
		d_s2     <= d_c;
		en_s2    <= en_s1;
		neg_s2   <= self_s1 || isa_s1;
		dbl_s2   <= self_s1;
		first_s2 <= self_s1;
		last_s2  <= last_s1;
		addr_s2  <= addr_s1;
		p1_s3    <= x1_s2 * k_s2;
		p2_s3    <= x2_s2 * d_s2;
		en_s3    <= en_s2;
		neg_s3   <= neg_s2;
		dbl_s3   <= dbl_s2;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		addr_s3  <= addr_s2;
		addr_s4  <= addr_s3;
		if (v_s3)
			acc_q <= acc_next;
	end

	// write ports
	logic          h_we, oh_we, v_we, f_we;
	logic [AW-1:0] h_wa, f_wa;
	logic signed [23:0] h_wd, oh_wd, v_wd, f_wd;

	always_comb begin
		h_we  = 1'b0;
		oh_we = 1'b0;
		v_we  = 1'b0;
		f_we  = 1'b0;
		h_wa  = cur_addr;
		f_wa  = cur_addr;
		h_wd  = '0;
		oh_wd = '0;
		v_wd  = '0;
		f_wd  = '0;
		if (uv_s1) begin
			h_wa  = addr_s1;
			oh_we = 1'b1;
			oh_wd = h_rd;
			h_we  = uin_s1;
			h_wd  = h_new;
			v_we  = uin_s1;
			v_wd  = v_new;
		end else if (cmd.op == CMD_CLEAR) begin
			h_we  = 1'b1;
			oh_we = 1'b1;
			v_we  = 1'b1;
		end else if (cmd.op == CMD_PATTERN) begin
			h_we = 1'b1;
			h_wd = pat_h;
			v_we = 1'b1;
		end else if (cmd.op == CMD_SET) begin
			h_wa = item_addr;
			h_we = inner;
			h_wd = amt_q;
		end
		if (last_s4) begin
			f_we = 1'b1;
			f_wa = addr_s4;
			f_wd = sat24(acc_q);
		end else if (cmd.op == CMD_CLEAR || cmd.op == CMD_PATTERN) begin
			f_we = 1'b1;
		end else if (cmd.op == CMD_ADDF_WR) begin
			f_we = inner;
			f_wa = item_addr;
			f_wd = sat24(34'(f_rd) + 34'(amt_q));
		end
	end

	always_ff @(posedge clk) begin
		if (h_we)
			h_mem[h_wa] <= h_wd;
		if (rd_en)
			h_rd <= h_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (oh_we)
			oh_mem[h_wa] <= oh_wd;
		if (rd_en)
			oh_rd <= oh_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (v_we)
			v_mem[h_wa] <= v_wd;
		if (rd_en)
			v_rd <= v_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (f_we)
			f_mem[f_wa] <= f_wd;
		if (rd_en)
			f_rd <= f_mem[rd_addr];
	end

	// result register
	logic rejected;
	assign rejected = ((act_q == ACT_SET || act_q == ACT_FORCE) && !inner)
		|| (act_q == ACT_READ && !readable);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status       <= rejected;
			height_out   <= (act_q == ACT_READ && readable) ? h_rd : '0;
			velocity_out <= (act_q == ACT_READ && readable) ? v_rd : '0;
		end
	end

endmodule

### rtl/core/msm_ctrl.sv
// ----------------------------------------------------------------------------
// msm_ctrl
// Sequencer: clearing sweep, tick passes, pattern sweep and item handshakes.
// ----------------------------------------------------------------------------
`include "mass_spring_membrane_step_macros.svh"

module msm_ctrl #(
	parameter int GRID_MAX = msm_pkg::GRID_MAX_DEF,
	localparam int CW = $clog2(GRID_MAX)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    action,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic [CW:0]   grid_n,
	output msm_pkg::cmd_t cmd,
	output logic [CW-1:0] ci,
	output logic [CW-1:0] cj
);
	import msm_pkg::*;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_UPDATE  = 4'd2;
	localparam logic [3:0] S_DRAIN_U = 4'd3;
	localparam logic [3:0] S_FORCE   = 4'd4;
	localparam logic [3:0] S_DRAIN_F = 4'd5;
	localparam logic [3:0] S_PREP    = 4'd6;
	localparam logic [3:0] S_PATTERN = 4'd7;
	localparam logic [3:0] S_SET     = 4'd8;
	localparam logic [3:0] S_ADDF_RD = 4'd9;
	localparam logic [3:0] S_ADDF_WR = 4'd10;
	localparam logic [3:0] S_READ    = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	localparam logic [2:0] DRAIN_UPD = 3'd2;
	localparam logic [2:0] DRAIN_FRC = 3'd6;

	logic [3:0]    state_q;
	logic [CW-1:0] ci_q, cj_q;
	logic [3:0]    nb_q;
	logic [2:0]    dcnt_q;
	logic          out_valid_q;
	logic [CW-1:0] last;
	logic          row_end, cell_end, accept;

	assign last     = (state_q == S_CLEAR) ? CW'(GRID_MAX - 1) : CW'(grid_n - 1'b1);
	assign row_end  = cj_q == last;
	assign cell_end = row_end && ci_q == last;
	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign ci = ci_q;
	assign cj = cj_q;

	always_comb begin
		cmd.nb       = nb_q;
		cmd.accept   = accept;
		cmd.load_out = state_q == S_DONE && (!out_valid_q || out_ready);
		case (state_q)
			S_CLEAR:   cmd.op = CMD_CLEAR;
			S_UPDATE:  cmd.op = CMD_UPDATE;
			S_FORCE:   cmd.op = CMD_FORCE;
			S_PREP:    cmd.op = CMD_PREP;
			S_PATTERN: cmd.op = CMD_PATTERN;
			S_SET:     cmd.op = CMD_SET;
			S_ADDF_RD: cmd.op = CMD_ADDF_RD;
			S_ADDF_WR: cmd.op = CMD_ADDF_WR;
			S_READ:    cmd.op = CMD_READ;
			default:   cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ci_q        <= '0;
			cj_q        <= '0;
			nb_q        <= NB_SELF;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_CLEAR, S_UPDATE, S_PATTERN: begin
					if (cell_end) begin
						ci_q <= '0;
						cj_q <= '0;
						dcnt_q <= DRAIN_UPD;
						case (state_q)
							S_CLEAR:  state_q <= S_IDLE;
							S_UPDATE: state_q <= S_DRAIN_U;
							default:  state_q <= S_DONE;
						endcase
					end else if (row_end) begin
						cj_q <= '0;
						ci_q <= ci_q + 1'b1;
					end else begin
						cj_q <= cj_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_TICK:    state_q <= S_UPDATE;
							ACT_SET:     state_q <= S_SET;
							ACT_FORCE:   state_q <= S_ADDF_RD;
							ACT_PATTERN: state_q <= S_PREP;
							ACT_READ:    state_q <= S_READ;
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_DRAIN_U: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0)
						state_q <= S_FORCE;
				end
				S_FORCE: begin
					if (nb_q == NB_LAST) begin
						nb_q <= NB_SELF;
						if (cell_end) begin
							ci_q    <= '0;
							cj_q    <= '0;
							dcnt_q  <= DRAIN_FRC;
							state_q <= S_DRAIN_F;
						end else if (row_end) begin
							cj_q <= '0;
							ci_q <= ci_q + 1'b1;
						end else begin
							cj_q <= cj_q + 1'b1;
						end
					end else begin
						nb_q <= nb_q + 1'b1;
					end
				end
				S_DRAIN_F: begin
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0)
						state_q <= S_DONE;
				end
				S_PREP:    state_q <= S_PATTERN;
				S_SET:     state_q <= S_DONE;
				S_ADDF_RD: state_q <= S_ADDF_WR;
				S_ADDF_WR: state_q <= S_DONE;
				S_READ:    state_q <= S_DONE;
				S_DONE: begin
					if (cmd.load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MSM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`MSM_ASSERT_NEXT(a_result_then_idle, cmd.load_out, out_valid_q && state_q == S_IDLE)
	`MSM_ASSERT(a_nb_range, nb_q <= NB_LAST)
	`MSM_ASSERT(a_nb_only_in_force, state_q == S_FORCE || nb_q == NB_SELF)

endmodule

### tb/sv/mass_spring_membrane_step_tb.sv
// ----------------------------------------------------------------------------
// mass_spring_membrane_step_tb
// Self-checking bench: drives action items through the membrane step block,
// predicts each result beat from an in-bench copy of the grid state, and
// compares status, height_out and velocity_out beat by beat.
// ----------------------------------------------------------------------------
module mass_spring_membrane_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msm_pkg::*;

	localparam int GM = GRID_MAX_DEF;
	localparam int IDLE_LIMIT = 250000;

	typedef struct {
		logic        status;
		logic [23:0] height;
		logic [23:0] velocity;
	} membrane_result_t;

	// grid predictor and store of expected result beats
	class membrane_scoreboard;
		int grid_cfg;
		longint k_orth, k_diag, k_ground, d_orth, d_diag, d_ground;
		int ht[GM*GM];
		int oh[GM*GM];
		int vel[GM*GM];
		int frc[GM*GM];
		longint accv[GM*GM];
		int stored_pat;
		membrane_result_t pending_q[$];
		int mismatches;

		function new();
			grid_cfg = GRID_SIZE_RST;
			k_orth = SPRING_ORTH_RST;
			k_diag = 0;
			k_ground = 0;
			d_orth = DAMP_ORTH_RST;
			d_diag = 0;
			d_ground = 0;
			for (int c = 0; c < GM*GM; c++) begin
				ht[c] = 0; oh[c] = 0; vel[c] = 0; frc[c] = 0; accv[c] = 0;
			end
			stored_pat = 1;
			mismatches = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [17:0] d);
			case (idx)
				REG_GRID_SIZE:     grid_cfg = int'(d[6:0]);
				REG_SPRING_ORTH:   k_orth = longint'($signed(d));
				REG_SPRING_DIAG:   k_diag = longint'($signed(d));
				REG_SPRING_GROUND: k_ground = longint'($signed(d));
				REG_DAMP_ORTH:     d_orth = longint'($signed(d));
				REG_DAMP_DIAG:     d_diag = longint'($signed(d));
				REG_DAMP_GROUND:   d_ground = longint'($signed(d));
				default: ;
			endcase
		endfunction

		function int side();
			if (grid_cfg < 3) return 3;
			if (grid_cfg > GM) return GM;
			return grid_cfg;
		endfunction

		function int sat24(longint v);
			if (v > 8388607) return 8388607;
			if (v < -8388608) return -8388608;
			return int'(v);
		endfunction

		// coefficient times difference, round half up after the 16 bit shift
		function longint scaled(longint coef, longint diff);
			longint p;
			p = coef * diff + 32768;
			return p >>> 16;
		endfunction

		function void spring_link(int a, int b, longint k, longint d);
			longint dh, doh, t;
			dh = longint'(ht[a]) - ht[b];
			doh = longint'(oh[a]) - oh[b];
			t = scaled(k, dh) + scaled(d, dh - doh);
			accv[a] -= t;
			accv[b] += t;
		endfunction

		function void advance_grid();
			int n, c;
			longint g;
			n = side();
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					oh[i*GM+j] = ht[i*GM+j];
					accv[i*GM+j] = 0;
				end
			for (int i = 1; i < n-1; i++)
				for (int j = 1; j < n-1; j++) begin
					c = i*GM+j;
					vel[c] = sat24(longint'(vel[c]) + frc[c]);
					ht[c] = sat24(longint'(ht[c]) + vel[c]);
				end
			for (int i = 1; i < n; i++)
				for (int j = 1; j < n; j++) begin
					spring_link(i*GM+j, i*GM+j-1, k_orth, d_orth);
					spring_link(i*GM+j, (i-1)*GM+j, k_orth, d_orth);
					spring_link(i*GM+j, (i-1)*GM+j-1, k_diag, d_diag);
				end
			for (int i = 0; i < n-1; i++)
				for (int j = 1; j < n; j++)
					spring_link(i*GM+j, (i+1)*GM+j-1, k_diag, d_diag);
			for (int i = 1; i < n-1; i++)
				for (int j = 1; j < n-1; j++) begin
					c = i*GM+j;
					g = scaled(d_ground, longint'(ht[c]) - oh[c]);
					accv[c] -= scaled(k_ground, longint'(ht[c]));
					accv[c] -= 2 * g;
				end
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++)
					frc[i*GM+j] = sat24(accv[i*GM+j]);
		endfunction

		function int pattern_height(int p, int n, int i, int j);
			int q4, q6, s;
			bit mid;
			q4 = (n/4) * 4096;
			q6 = (n/6) * 4096;
			mid = i > n/3 && j > n/3 && i < (2*n)/3 && j < (2*n)/3;
			s = (n - i) - j;
			case (p)
				2: return (i == j && i == n/2) ? n * 6144 : 0;
				3: return (s < 3 && s > 0) ? q6 : 0;
				4: return (i == 1) ? q4 : 0;
				5: return mid ? 0 : q4;
				6: return mid ? q4 : 0;
				7: return (s < 3) ? q6 : 0;
				8: return (i > (3*n)/4 && j > (3*n)/4) ? q4 : 0;
				default: return 0;
			endcase
		endfunction

		function void reload_grid(int p);
			int n, c;
			n = side();
			if (p >= 1 && p <= 8) stored_pat = p;
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					c = i*GM+j;
					frc[c] = 0;
					vel[c] = 0;
					if (i == 0 || j == 0 || i == n-1 || j == n-1) ht[c] = 0;
					else ht[c] = pattern_height(stored_pat, n, i, j);
				end
		endfunction

		function void note_input(logic [2:0] act, logic [5:0] ci, logic [5:0] ri,
				logic [23:0] amt, logic [3:0] pat);
			membrane_result_t r;
			int n, i, j, c;
			bit inner;
			n = side();
			i = int'(ci);
			j = int'(ri);
			c = i*GM+j;
			inner = i > 0 && i < n-1 && j > 0 && j < n-1;
			r.status = 1'b0;
			r.height = '0;
			r.velocity = '0;
			case (act)
				ACT_TICK: advance_grid();
				ACT_SET: if (inner) ht[c] = int'($signed(amt)); else r.status = 1'b1;
				ACT_FORCE:
					if (inner) frc[c] = sat24(longint'(frc[c]) + int'($signed(amt)));
					else r.status = 1'b1;
				ACT_PATTERN: reload_grid(pat > 8 ? 0 : int'(pat));
				ACT_READ:
					if (i < n && j < n) begin
						r.height = ht[c][23:0];
						r.velocity = vel[c][23:0];
					end else begin
						r.status = 1'b1;
					end
				default: ;
			endcase
			pending_q.push_back(r);
		endfunction

		function void check_result(logic st, logic [23:0] h, logic [23:0] v);
			membrane_result_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d height %h velocity %h",
						st, h, v);
				return;
			end
			e = pending_q.pop_front();
			if (st !== e.status || h !== e.height || v !== e.velocity) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: exp st %0d h %h v %h, got st %0d h %h v %h",
						e.status, e.height, e.velocity, st, h, v);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [17:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         action;
	logic [5:0]         col;
	logic [5:0]         row;
	logic signed [23:0] amount;
	logic [3:0]         pattern;
	logic               out_valid;
	logic               out_ready;
	logic               status;
	logic signed [23:0] height_out;
	logic signed [23:0] velocity_out;

	membrane_scoreboard sb = new();

	// 0 none, 1 sender gaps, 2 receiver stalls, 3 both
	int idle_mode = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;
	int idle_cycles = 0;

	mass_spring_membrane_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .col(col), .row(row), .amount(amount), .pattern(pattern),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .height_out(height_out), .velocity_out(velocity_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt <= 300;
			out_ready <= 1'b0;
		end else if (idle_mode == 2) begin
			out_ready <= ($urandom_range(99) >= 67);
		end else if (idle_mode == 3) begin
			out_ready <= ($urandom_range(99) >= 15);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(status, height_out, velocity_out);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(logic [2:0] a, logic [5:0] c, logic [5:0] r,
			logic [23:0] amt, logic [3:0] p);
		int gap;
		gap = 0;
		if ((idle_mode == 1 && $urandom_range(99) < 67) ||
				(idle_mode == 3 && $urandom_range(99) < 15))
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		col <= c;
		row <= r;
		amount <= amt;
		pattern <= p;
		do @(posedge clk); while (!in_ready);
		sb.note_input(a, c, r, amt, p);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_regs(logic [6:0] gsize, logic [17:0] k1, logic [17:0] k2,
			logic [17:0] k3, logic [17:0] d1, logic [17:0] d2, logic [17:0] d3);
		logic [17:0] vals[7];
		vals = '{{11'd0, gsize}, k1, k2, k3, d1, d2, d3};
		for (int idx = 0; idx < 7; idx++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[2:0];
			cfg_data <= vals[idx];
			sb.set_reg(idx[2:0], vals[idx]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [17:0] pick_coef();
		case ($urandom_range(3))
			0: return 18'($urandom);
			1: return 18'($urandom_range(16000) - 8000);
			2: return 18'd0;
			default: return $urandom_range(1) ? 18'h1FFFF : 18'h20000;
		endcase
	endfunction

	task automatic random_item(int n, ref int ticks_left);
		logic [2:0] a;
		logic [5:0] c, r;
		logic [23:0] amt;
		int sel;
		sel = $urandom_range(99);
		if (sel < 20) a = ACT_TICK;
		else if (sel < 45) a = ACT_SET;
		else if (sel < 65) a = ACT_FORCE;
		else if (sel < 75) a = ACT_PATTERN;
		else if (sel < 95) a = ACT_READ;
		else a = 3'($urandom_range(5, 7));
		if (a == ACT_TICK) begin
			if (ticks_left == 0) a = ACT_READ;
			else ticks_left--;
		end
		if ($urandom_range(3) == 0) begin
			c = 6'($urandom);
			r = 6'($urandom);
		end else begin
			c = 6'($urandom_range(n));
			r = 6'($urandom_range(n));
		end
		amt = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(65536) - 32768);
		send_item(a, c, r, amt, 4'($urandom));
	endtask

	initial begin
		int n, ticks_left;
		logic [6:0] sizes[8];
		sizes = '{7'd4, 7'd5, 7'd1, 7'd8, 7'd127, 7'd6, 7'd7, 7'd10};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		action = '0;
		col = '0;
		row = '0;
		amount = '0;
		pattern = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, 50 by 50 grid
		send_item(ACT_READ, 6'd0, 6'd0, 24'd0, 4'd0);
		send_item(ACT_READ, 6'd49, 6'd49, 24'd0, 4'd0);
		send_item(ACT_READ, 6'd50, 6'd3, 24'd0, 4'd0);
		send_item(ACT_SET, 6'd25, 6'd25, 24'h7FFFFF, 4'd0);
		send_item(ACT_FORCE, 6'd24, 6'd25, 24'h800000, 4'd0);
		send_item(ACT_TICK, 6'd0, 6'd0, 24'd0, 4'd0);
		send_item(ACT_READ, 6'd25, 6'd25, 24'd0, 4'd0);
		drain();

		// smallest grid, largest coefficients
		write_regs(7'd0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
		send_item(ACT_SET, 6'd1, 6'd1, 24'h7FFFFF, 4'd0);
		send_item(ACT_SET, 6'd0, 6'd1, 24'd5, 4'd0);
		send_item(ACT_FORCE, 6'd1, 6'd2, 24'd5, 4'd0);
		send_item(ACT_FORCE, 6'd1, 6'd1, 24'h800000, 4'd0);
		send_item(ACT_FORCE, 6'd1, 6'd1, 24'h800000, 4'd0);
		send_item(ACT_TICK, 6'd0, 6'd0, 24'd0, 4'd0);
		send_item(ACT_READ, 6'd1, 6'd1, 24'd0, 4'd0);
		send_item(ACT_READ, 6'd63, 6'd63, 24'd0, 4'd0);
		drain();
		write_regs(7'd12, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000);
		for (int p = 0; p <= 8; p++) begin
			send_item(ACT_PATTERN, 6'd0, 6'd0, 24'd0, 4'(p));
			send_item(ACT_READ, 6'($urandom_range(11)), 6'($urandom_range(11)), 24'd0, 4'd0);
		end
		send_item(ACT_PATTERN, 6'd0, 6'd0, 24'd0, 4'd15);
		send_item(3'd5, 6'd1, 6'd1, 24'd1, 4'd0);
		send_item(3'd7, 6'd63, 6'd0, 24'd1, 4'd0);
		send_item(ACT_TICK, 6'd0, 6'd0, 24'd0, 4'd0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_regs(sizes[ph], pick_coef(), pick_coef(), pick_coef(),
				pick_coef(), pick_coef(), pick_coef());
			n = sb.side();
			ticks_left = (n > 16) ? 2 : 100;
			idle_mode = ph % 4;
			// long receiver hold-off while items keep coming
			if (ph == 0) hold_req = 1'b1;
			send_item(ACT_PATTERN, 6'd0, 6'd0, 24'd0, 4'($urandom_range(1, 8)));
			for (int k = 0; k < 12; k++) random_item(n, ticks_left);
			drain();
		end

		idle_mode = 0;
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/msm_pkg.sv
rtl/core/msm_dp.sv
rtl/core/msm_ctrl.sv
rtl/core/mass_spring_membrane_step.sv
tb/sv/mass_spring_membrane_step_tb.sv
